FILE: design/rmie_pkg.sv
// ----------------------------------------------------------------------------
// rmie_pkg
// shared codes for the rendezvous message engine
// ----------------------------------------------------------------------------
package rmie_pkg;
   typedef enum logic [1:0] {
      CMD_SEND = 2'd0,
      CMD_RECV = 2'd1,
      CMD_IRQ  = 2'd2,
      CMD_BAD  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PEER_NAMED = 2'd0,
      PEER_ANY   = 2'd1,
      PEER_IRQ   = 2'd2,
      PEER_BAD   = 2'd3
   } peer_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_BLOCKED  = 2'd1,
      ST_DEADLOCK = 2'd2,
      ST_ILLEGAL  = 2'd3
   } status_type;
endpackage

FILE: design/rendezvous_message_ipc_engine_top.sv
// ----------------------------------------------------------------------------
// rendezvous_message_ipc_engine_top
// synchronous rendezvous message passing between processes
// ----------------------------------------------------------------------------
// One request at a time. A request is taken when the engine is idle; it is
// then decoded. A send walks the send-to chain one process a cycle to refuse
// deadlock; a receive from a named sender walks the caller's waiting-sender
// list one entry a cycle to find its predecessor. Held messages live in
// flip-flop arrays indexed by process. The response sits in an output
// register until taken.
module rendezvous_message_ipc_engine_top #(
   parameter int NUM_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [3:0]  req_caller_pid,
   input  logic [1:0]  req_peer_kind,
   input  logic [3:0]  req_peer_pid,
   input  logic [31:0] req_msg_kind,
   input  logic [63:0] req_msg_body,
   input  logic        csr_write,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_deliver_valid,
   output logic [3:0]  rsp_deliver_pid,
   output logic [3:0]  rsp_from_pid,
   output logic        rsp_from_interrupt,
   output logic [31:0] rsp_out_kind,
   output logic [63:0] rsp_out_body,
   output logic        rsp_woken_valid,
   output logic [3:0]  rsp_woken_pid
);
   import rmie_pkg::*;

   // process index with room for the empty marker NUM_PROCS
   localparam int PW = $clog2(NUM_PROCS + 1);
   localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam logic [PW-1:0] NONE = PW'(NUM_PROCS);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_CHAIN, S_SEND, S_SEARCH, S_TAKE, S_RESP
   } state_type;

   state_type state_ff;

   // per-process state
   logic [NUM_PROCS-1:0] sending_ff, receiving_ff, irq_pend_ff;
   logic [PW-1:0] target_ff [NUM_PROCS];
   logic [1:0]    fkind_ff  [NUM_PROCS];
   logic [PW-1:0] fpid_ff   [NUM_PROCS];
   logic [PW-1:0] head_ff   [NUM_PROCS];
   logic [PW-1:0] tail_ff   [NUM_PROCS];
   logic [PW-1:0] link_ff   [NUM_PROCS];
   logic [31:0]   hkind_ff  [NUM_PROCS];
   logic [63:0]   hbody_ff  [NUM_PROCS];
   logic [31:0]   hard_int_ff;

   // latched request
   cmd_type       cmd_ff;
   logic [PW-1:0] me_ff, peer_ff;
   logic [1:0]    kind_ff;
   logic [31:0]   mk_ff;
   logic [63:0]   mb_ff;

   // walk registers: p is the current node, prev its predecessor
   logic [PW-1:0] p_ff, prev_ff, who_ff;
   logic [PW:0]   steps_ff;

   logic [1:0]  o_status_ff;
   logic        o_dv_ff, o_fi_ff, o_wv_ff;
   logic [3:0]  o_dp_ff, o_fp_ff, o_wp_ff;
   logic [31:0] o_kind_ff;
   logic [63:0] o_body_ff;

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_status         = o_status_ff;
   assign rsp_deliver_valid  = o_dv_ff;
   assign rsp_deliver_pid    = o_dp_ff;
   assign rsp_from_pid       = o_fp_ff;
   assign rsp_from_interrupt = o_fi_ff;
   assign rsp_out_kind       = o_kind_ff;
   assign rsp_out_body       = o_body_ff;
   assign rsp_woken_valid    = o_wv_ff;
   assign rsp_woken_pid      = o_wp_ff;

   // shared index fields
   logic [IW-1:0] me_i, peer_i, p_i, prev_i, who_i;
   assign me_i   = me_ff[IW-1:0];
   assign peer_i = peer_ff[IW-1:0];
   assign p_i    = p_ff[IW-1:0];
   assign prev_i = prev_ff[IW-1:0];
   assign who_i  = who_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sending_ff   <= '0;
         receiving_ff <= '0;
         irq_pend_ff  <= '0;
         hard_int_ff  <= 32'd1;
         for (int i = 0; i < NUM_PROCS; i++) begin
            target_ff[i] <= '0;
            fkind_ff[i]  <= '0;
            fpid_ff[i]   <= '0;
            head_ff[i]   <= NONE;
            tail_ff[i]   <= NONE;
            link_ff[i]   <= NONE;
         end
      end else begin
         if (csr_write) hard_int_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff  <= cmd_type'(req_cmd);
                  me_ff   <= PW'(req_caller_pid);
                  kind_ff <= req_peer_kind;
                  peer_ff <= PW'(req_peer_pid);
                  mk_ff   <= req_msg_kind;
                  mb_ff   <= req_msg_body;
                  // response starts out as a bare completion
                  o_status_ff <= ST_DONE;
                  o_dv_ff <= 1'b0; o_dp_ff <= '0; o_fp_ff <= '0; o_fi_ff <= 1'b0;
                  o_kind_ff <= '0; o_body_ff <= '0; o_wv_ff <= 1'b0; o_wp_ff <= '0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (cmd_ff == CMD_BAD || me_ff >= NONE) begin
                  o_status_ff <= ST_ILLEGAL;
                  state_ff <= S_RESP;
               end else if (cmd_ff == CMD_IRQ) begin
                  if (receiving_ff[me_i] && fkind_ff[me_i] != PEER_NAMED) begin
                     receiving_ff[me_i] <= 1'b0;
                     fkind_ff[me_i] <= '0;
                     fpid_ff[me_i]  <= '0;
                     o_dv_ff <= 1'b1; o_dp_ff <= 4'(me_ff); o_fi_ff <= 1'b1;
                     o_kind_ff <= hard_int_ff;
                     o_wv_ff <= 1'b1; o_wp_ff <= 4'(me_ff);
                  end else begin
                     irq_pend_ff[me_i] <= 1'b1;
                  end
                  state_ff <= S_RESP;
               end else if (kind_ff == PEER_BAD || sending_ff[me_i] ||
                            receiving_ff[me_i] ||
                            (kind_ff == PEER_NAMED &&
                             (peer_ff >= NONE || peer_ff == me_ff))) begin
                  o_status_ff <= ST_ILLEGAL;
                  state_ff <= S_RESP;
               end else if (cmd_ff == CMD_SEND) begin
                  if (kind_ff != PEER_NAMED) begin
                     o_status_ff <= ST_ILLEGAL;
                     state_ff <= S_RESP;
                  end else begin
                     p_ff <= peer_ff;
                     steps_ff <= '0;
                     state_ff <= S_CHAIN;
                  end
               end else if (irq_pend_ff[me_i] && kind_ff != PEER_NAMED) begin
                  irq_pend_ff[me_i] <= 1'b0;
                  o_dv_ff <= 1'b1; o_dp_ff <= 4'(me_ff); o_fi_ff <= 1'b1;
                  o_kind_ff <= hard_int_ff;
                  state_ff <= S_RESP;
               end else if (kind_ff == PEER_ANY && head_ff[me_i] < NONE) begin
                  // head has no predecessor
                  who_ff <= head_ff[me_i];
                  p_ff <= head_ff[me_i];
                  prev_ff <= NONE;
                  state_ff <= S_TAKE;
               end else if (kind_ff == PEER_NAMED && sending_ff[peer_i] &&
                            target_ff[peer_i] == me_ff) begin
                  who_ff <= peer_ff;
                  p_ff <= head_ff[me_i];
                  prev_ff <= NONE;
                  steps_ff <= '0;
                  state_ff <= S_SEARCH;
               end else begin
                  receiving_ff[me_i] <= 1'b1;
                  fkind_ff[me_i] <= kind_ff;
                  fpid_ff[me_i]  <= (kind_ff == PEER_NAMED) ? peer_ff : '0;
                  o_status_ff <= ST_BLOCKED;
                  state_ff <= S_RESP;
               end
            end
            S_CHAIN: begin
               // one link of the send-to chain per cycle
               if (steps_ff > (PW+1)'(NUM_PROCS) || p_ff >= NONE ||
                   !sending_ff[p_i]) begin
                  state_ff <= S_SEND;
               end else if (target_ff[p_i] == me_ff) begin
                  o_status_ff <= ST_DEADLOCK;
                  state_ff <= S_RESP;
               end else begin
                  p_ff <= target_ff[p_i];
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_SEND: begin
               state_ff <= S_RESP;
               if (receiving_ff[peer_i] &&
                   ((fkind_ff[peer_i] == PEER_NAMED && fpid_ff[peer_i] == me_ff) ||
                    fkind_ff[peer_i] == PEER_ANY)) begin
                  receiving_ff[peer_i] <= 1'b0;
                  fkind_ff[peer_i] <= '0;
                  fpid_ff[peer_i]  <= '0;
                  o_dv_ff <= 1'b1; o_dp_ff <= 4'(peer_ff); o_fp_ff <= 4'(me_ff);
                  o_kind_ff <= mk_ff; o_body_ff <= mb_ff;
                  o_wv_ff <= 1'b1; o_wp_ff <= 4'(peer_ff);
               end else begin
                  sending_ff[me_i] <= 1'b1;
                  target_ff[me_i] <= peer_ff;
                  hkind_ff[me_i] <= mk_ff;
                  hbody_ff[me_i] <= mb_ff;
                  link_ff[me_i] <= NONE;
                  if (tail_ff[peer_i] < NONE && head_ff[peer_i] < NONE)
                     link_ff[tail_ff[peer_i][IW-1:0]] <= me_ff;
                  else
                     head_ff[peer_i] <= me_ff;
                  tail_ff[peer_i] <= me_ff;
                  o_status_ff <= ST_BLOCKED;
               end
            end
            S_SEARCH: begin
               // find the named sender's predecessor in the caller's list
               if (steps_ff >= (PW+1)'(NUM_PROCS) || p_ff >= NONE) begin
                  p_ff <= NONE;
                  state_ff <= S_TAKE;
               end else if (p_ff == who_ff) begin
                  state_ff <= S_TAKE;
               end else begin
                  prev_ff <= p_ff;
                  p_ff <= link_ff[p_i];
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_TAKE: begin
               if (p_ff < NONE) begin
                  if (prev_ff < NONE) link_ff[prev_i] <= link_ff[p_i];
                  else                head_ff[me_i]   <= link_ff[p_i];
                  if (tail_ff[me_i] == who_ff) tail_ff[me_i] <= prev_ff;
                  link_ff[p_i] <= NONE;
               end
               o_dv_ff <= 1'b1; o_dp_ff <= 4'(me_ff); o_fp_ff <= 4'(who_ff);
               o_kind_ff <= hkind_ff[who_i]; o_body_ff <= hbody_ff[who_i];
               o_wv_ff <= 1'b1; o_wp_ff <= 4'(who_ff);
               sending_ff[who_i] <= 1'b0;
               target_ff[who_i] <= '0;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: tb/rendezvous_message_ipc_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rendezvous_message_ipc_engine_top_test
// self-checking bench for the rendezvous message engine: a directed table of
// calls followed by random, mostly well-formed call sequences under several
// idling phases, every response compared against a table row or a predictor
// ----------------------------------------------------------------------------
module rendezvous_message_ipc_engine_top_test;
   import rmie_pkg::*;

   localparam int NPROC      = 16;
   localparam int EMPTY      = 16;      // list terminator
   localparam int RAND_ITEMS = 1850;
   localparam int IDLE_LIMIT = 20000;   // cycles with no handshake at all
   localparam int DRAIN_WAIT = 40;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  caller;
      peer_type    pkind;
      logic [3:0]  ppid;
      logic [31:0] mkind;
      logic [63:0] mbody;
   } call_type;

   typedef struct packed {
      status_type  status;
      logic        dv;
      logic [3:0]  dpid;
      logic [3:0]  fpid;
      logic        fi;
      logic [31:0] okind;
      logic [63:0] obody;
      logic        wv;
      logic [3:0]  wpid;
   } outcome_type;

   typedef struct packed {
      call_type    c;
      logic        typed;   // expectation written into the table
      outcome_type o;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [3:0]  req_caller_pid = '0;
   logic [1:0]  req_peer_kind = '0;
   logic [3:0]  req_peer_pid = '0;
   logic [31:0] req_msg_kind = '0;
   logic [63:0] req_msg_body = '0;
   logic        csr_write = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_deliver_valid;
   logic [3:0]  rsp_deliver_pid;
   logic [3:0]  rsp_from_pid;
   logic        rsp_from_interrupt;
   logic [31:0] rsp_out_kind;
   logic [63:0] rsp_out_body;
   logic        rsp_woken_valid;
   logic [3:0]  rsp_woken_pid;

   rendezvous_message_ipc_engine_top #(.NUM_PROCS(NPROC)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_caller_pid(req_caller_pid),
      .req_peer_kind(req_peer_kind), .req_peer_pid(req_peer_pid),
      .req_msg_kind(req_msg_kind), .req_msg_body(req_msg_body),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_deliver_valid(rsp_deliver_valid),
      .rsp_deliver_pid(rsp_deliver_pid), .rsp_from_pid(rsp_from_pid),
      .rsp_from_interrupt(rsp_from_interrupt), .rsp_out_kind(rsp_out_kind),
      .rsp_out_body(rsp_out_body), .rsp_woken_valid(rsp_woken_valid),
      .rsp_woken_pid(rsp_woken_pid)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor state: a shadow copy of the per-process ipc tables
   // ------------------------------------------------------------------------
   logic [31:0] irq_type_word;
   logic        sending   [NPROC];
   logic        receiving [NPROC];
   logic [3:0]  send_to   [NPROC];
   peer_type    wait_kind [NPROC];
   logic [3:0]  wait_pid  [NPROC];
   logic [4:0]  q_head    [NPROC];
   logic [4:0]  q_tail    [NPROC];
   logic [4:0]  q_next    [NPROC];
   logic [31:0] held_kind [NPROC];
   logic [63:0] held_body [NPROC];
   logic        irq_flag  [NPROC];

   outcome_type pending_rsps[$];   // responses still owed by the engine
   int          errors = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0; // sender gap chance per cycle
   int          recv_stall_pct = 0; // receiver stall chance per cycle

   // remove a waiting sender from an owner's fifo, fixing head and tail
   function automatic void unlink_waiter(int owner, int who);
      int p, prev, nx, steps;
      p = int'(q_head[owner]);
      prev = EMPTY;
      for (steps = 0; steps < NPROC && p < NPROC; steps++) begin
         if (p == who) begin
            nx = int'(q_next[p]);
            if (prev < NPROC) q_next[prev] = nx[4:0];
            else q_head[owner] = nx[4:0];
            if (int'(q_tail[owner]) == who) q_tail[owner] = prev[4:0];
            q_next[p] = 5'(EMPTY);
            return;
         end
         prev = p;
         p = int'(q_next[p]);
      end
   endfunction

   // hand a held message from a blocked sender to its receiver
   function automatic outcome_type collect_held(int me, int from);
      outcome_type o;
      o = '0;
      o.status = ST_DONE;
      o.dv = 1'b1; o.dpid = me[3:0]; o.fpid = from[3:0];
      o.okind = held_kind[from]; o.obody = held_body[from];
      o.wv = 1'b1; o.wpid = from[3:0];
      sending[from] = 1'b0;
      send_to[from] = '0;
      return o;
   endfunction

   function automatic outcome_type irq_notice(int me);
      outcome_type o;
      o = '0;
      o.status = ST_DONE;
      o.dv = 1'b1; o.dpid = me[3:0]; o.fi = 1'b1; o.okind = irq_type_word;
      return o;
   endfunction

   // advance the shadow tables by one call and return its response
   function automatic outcome_type predict_outcome(call_type c);
      outcome_type o;
      int me, peer, p, steps;
      logic hit;
      me = int'(c.caller);
      peer = int'(c.ppid);
      o = '0;
      o.status = ST_DONE;
      if (c.cmd == CMD_BAD) begin
         o.status = ST_ILLEGAL;
         return o;
      end
      if (c.cmd == CMD_IRQ) begin
         if (receiving[me] && wait_kind[me] != PEER_NAMED) begin
            receiving[me] = 1'b0; wait_kind[me] = PEER_NAMED; wait_pid[me] = '0;
            o = irq_notice(me);
            o.wv = 1'b1; o.wpid = me[3:0];
         end else begin
            irq_flag[me] = 1'b1;
         end
         return o;
      end
      if (c.pkind == PEER_BAD || sending[me] || receiving[me] ||
          (c.pkind == PEER_NAMED && peer == me)) begin
         o.status = ST_ILLEGAL;
         return o;
      end
      if (c.cmd == CMD_SEND) begin
         if (c.pkind != PEER_NAMED) begin
            o.status = ST_ILLEGAL;
            return o;
         end
         // follow the chain of blocked senders from the target
         hit = 1'b0;
         p = peer;
         for (steps = 0; steps <= NPROC; steps++) begin
            if (!sending[p]) break;
            if (int'(send_to[p]) == me) begin
               hit = 1'b1;
               break;
            end
            p = int'(send_to[p]);
         end
         if (hit) begin
            o.status = ST_DEADLOCK;
            return o;
         end
         if (receiving[peer] &&
             ((wait_kind[peer] == PEER_NAMED && int'(wait_pid[peer]) == me) ||
              wait_kind[peer] == PEER_ANY)) begin
            receiving[peer] = 1'b0; wait_kind[peer] = PEER_NAMED; wait_pid[peer] = '0;
            o.dv = 1'b1; o.dpid = peer[3:0]; o.fpid = me[3:0];
            o.okind = c.mkind; o.obody = c.mbody;
            o.wv = 1'b1; o.wpid = peer[3:0];
            return o;
         end
         sending[me] = 1'b1;
         send_to[me] = peer[3:0];
         held_kind[me] = c.mkind;
         held_body[me] = c.mbody;
         q_next[me] = 5'(EMPTY);
         if (q_tail[peer] < NPROC && q_head[peer] < NPROC) q_next[q_tail[peer]] = me[4:0];
         else q_head[peer] = me[4:0];
         q_tail[peer] = me[4:0];
         o.status = ST_BLOCKED;
         return o;
      end
      // receive: interrupt first, then fifo head or named sender
      if (irq_flag[me] && c.pkind != PEER_NAMED) begin
         irq_flag[me] = 1'b0;
         return irq_notice(me);
      end
      if (c.pkind == PEER_ANY && q_head[me] < NPROC) begin
         p = int'(q_head[me]);
         unlink_waiter(me, p);
         return collect_held(me, p);
      end
      if (c.pkind == PEER_NAMED && sending[peer] && int'(send_to[peer]) == me) begin
         unlink_waiter(me, peer);
         return collect_held(me, peer);
      end
      receiving[me] = 1'b1;
      wait_kind[me] = c.pkind;
      wait_pid[me] = (c.pkind == PEER_NAMED) ? peer[3:0] : 4'd0;
      o.status = ST_BLOCKED;
      return o;
   endfunction

   function automatic void clear_tables();
      irq_type_word = 32'd1;
      for (int i = 0; i < NPROC; i++) begin
         sending[i] = 1'b0; receiving[i] = 1'b0; send_to[i] = '0;
         wait_kind[i] = PEER_NAMED; wait_pid[i] = '0;
         q_head[i] = 5'(EMPTY); q_tail[i] = 5'(EMPTY); q_next[i] = 5'(EMPTY);
         held_kind[i] = '0; held_body[i] = '0; irq_flag[i] = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // random call generation, biased towards calls that move the tables on
   // ------------------------------------------------------------------------
   function automatic int pick_free_caller();
      int cand[$];
      for (int i = 0; i < NPROC; i++)
         if (!sending[i] && !receiving[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
   endfunction

   function automatic int other_than(int me);
      int p;
      p = (me + int'($urandom_range(1, NPROC - 1))) % NPROC;
      return p;
   endfunction

   function automatic call_type random_call();
      call_type c;
      int r, me, w;
      int waiting[$];
      c.mkind = $urandom;
      c.mbody = {$urandom, $urandom};
      c.ppid = 4'($urandom_range(NPROC - 1));
      r = int'($urandom_range(99));
      me = pick_free_caller();
      // noise: any field pattern at all, broken calls included
      if (r < 10) begin
         c.cmd = cmd_type'($urandom_range(3));
         c.caller = 4'($urandom_range(NPROC - 1));
         c.pkind = peer_type'($urandom_range(3));
         return c;
      end
      // nobody free, or a raise: post an interrupt notice
      if (me < 0 || r < 22) begin
         c.cmd = CMD_IRQ;
         c.caller = 4'($urandom_range(NPROC - 1));
         c.pkind = peer_type'($urandom_range(3));
         return c;
      end
      c.caller = me[3:0];
      if (r < 60) begin
         c.cmd = CMD_SEND;
         c.pkind = PEER_NAMED;
         c.ppid = 4'(other_than(me));
         return c;
      end
      c.cmd = CMD_RECV;
      w = int'($urandom_range(99));
      c.pkind = (w < 40) ? PEER_NAMED : (w < 80) ? PEER_ANY : PEER_IRQ;
      if (c.pkind == PEER_NAMED) begin
         for (int i = 0; i < NPROC; i++)
            if (sending[i] && int'(send_to[i]) == me) waiting.push_back(i);
         if (waiting.size() != 0 && $urandom_range(99) < 70)
            c.ppid = 4'(waiting[$urandom_range(waiting.size() - 1)]);
         else
            c.ppid = 4'(other_than(me));
      end
      return c;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: payload and valid change only at a rising edge
   // ------------------------------------------------------------------------
   task automatic issue_call(call_type c, logic typed, outcome_type fixed);
      outcome_type o;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= c.cmd;
      req_caller_pid <= c.caller;
      req_peer_kind  <= c.pkind;
      req_peer_pid   <= c.ppid;
      req_msg_kind   <= c.mkind;
      req_msg_body   <= c.mbody;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge: shadow tables always advance
      o = predict_outcome(c);
      pending_rsps.push_back(typed ? fixed : o);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_irq_type(logic [31:0] v);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      irq_type_word = v;
   endtask

   // ------------------------------------------------------------------------
   // response checker and receiver stall
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               report_mismatch("unexpected response", 64'd1, 64'd0);
            end else begin
               e = pending_rsps.pop_front();
               if (rsp_status != e.status)
                  report_mismatch("status", 64'(rsp_status), 64'(e.status));
               if (rsp_deliver_valid != e.dv)
                  report_mismatch("deliver_valid", 64'(rsp_deliver_valid), 64'(e.dv));
               if (rsp_deliver_pid != e.dpid)
                  report_mismatch("deliver_pid", 64'(rsp_deliver_pid), 64'(e.dpid));
               if (rsp_from_pid != e.fpid)
                  report_mismatch("from_pid", 64'(rsp_from_pid), 64'(e.fpid));
               if (rsp_from_interrupt != e.fi)
                  report_mismatch("from_interrupt", 64'(rsp_from_interrupt), 64'(e.fi));
               if (rsp_out_kind != e.okind)
                  report_mismatch("out_kind", 64'(rsp_out_kind), 64'(e.okind));
               if (rsp_out_body != e.obody) report_mismatch("out_body", rsp_out_body, e.obody);
               if (rsp_woken_valid != e.wv)
                  report_mismatch("woken_valid", 64'(rsp_woken_valid), 64'(e.wv));
               if (rsp_woken_pid != e.wpid)
                  report_mismatch("woken_pid", 64'(rsp_woken_pid), 64'(e.wpid));
            end
         end
      end
   end

   // watchdog: any handshake on either channel, or a csr write, restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------------
   row_type table_rows[$];

   function automatic void add_row(cmd_type cmd, int caller, peer_type pk, int pp,
                                   logic [31:0] mk, logic [63:0] mb,
                                   logic typed, status_type st);
      row_type r;
      r.c = '{cmd, caller[3:0], pk, pp[3:0], mk, mb};
      r.typed = typed;
      r.o = '0;
      r.o.status = st;
      table_rows.push_back(r);
   endfunction

   initial begin
      call_type c;
      int phase_items;
      clear_tables();

      // bad command, bad peer kinds, self send, send to any or irq
      add_row(CMD_BAD,  0,  PEER_NAMED, 1, '0, '0, 1'b1, ST_ILLEGAL);
      add_row(CMD_SEND, 0,  PEER_ANY,   1, '0, '0, 1'b1, ST_ILLEGAL);
      add_row(CMD_SEND, 0,  PEER_IRQ,   1, '0, '0, 1'b1, ST_ILLEGAL);
      add_row(CMD_SEND, 15, PEER_NAMED, 15, '1, '1, 1'b1, ST_ILLEGAL);
      add_row(CMD_RECV, 1,  PEER_BAD,   0, '0, '0, 1'b1, ST_ILLEGAL);
      // receiver waiting on any sender gets the message straight away
      add_row(CMD_RECV, 1,  PEER_ANY,   0, '0, '0, 1'b1, ST_BLOCKED);
      add_row(CMD_SEND, 1,  PEER_NAMED, 2, '0, '0, 1'b1, ST_ILLEGAL);
      add_row(CMD_SEND, 2,  PEER_NAMED, 1, '1, '1, 1'b0, ST_DONE);
      // two senders queue on process 4, then a cycle is refused
      add_row(CMD_SEND, 3,  PEER_NAMED, 4, 32'h1234_5678, 64'hdead_beef_0bad_f00d,
              1'b1, ST_BLOCKED);
      add_row(CMD_SEND, 5,  PEER_NAMED, 4, '0, '0, 1'b1, ST_BLOCKED);
      add_row(CMD_SEND, 4,  PEER_NAMED, 3, '0, '0, 1'b1, ST_DEADLOCK);
      add_row(CMD_SEND, 3,  PEER_NAMED, 6, '0, '0, 1'b1, ST_ILLEGAL);
      // named receive takes the queue tail, any takes the head
      add_row(CMD_RECV, 4,  PEER_NAMED, 5, '0, '0, 1'b0, ST_DONE);
      add_row(CMD_RECV, 4,  PEER_ANY,   0, '0, '0, 1'b0, ST_DONE);
      // pending notice is passed over by a named receive
      add_row(CMD_IRQ,  6,  PEER_BAD,  15, '1, '1, 1'b1, ST_DONE);
      add_row(CMD_RECV, 6,  PEER_NAMED, 7, '0, '0, 1'b1, ST_BLOCKED);
      add_row(CMD_IRQ,  6,  PEER_NAMED, 0, '0, '0, 1'b1, ST_DONE);
      add_row(CMD_SEND, 7,  PEER_NAMED, 6, 32'h0, 64'h0, 1'b0, ST_DONE);
      // notice taken by an interrupt receive, and one delivered to a waiter
      add_row(CMD_IRQ,  8,  PEER_NAMED, 0, '0, '0, 1'b1, ST_DONE);
      add_row(CMD_RECV, 8,  PEER_IRQ,   0, '0, '0, 1'b0, ST_DONE);
      add_row(CMD_RECV, 9,  PEER_IRQ,   0, '0, '0, 1'b1, ST_BLOCKED);
      add_row(CMD_IRQ,  9,  PEER_NAMED, 0, '0, '0, 1'b0, ST_DONE);
      add_row(CMD_RECV, 15, PEER_ANY,   0, '0, '0, 1'b1, ST_BLOCKED);
      add_row(CMD_SEND, 0,  PEER_NAMED, 15, '1, '1, 1'b0, ST_DONE);

      // single synchronous reset pulse
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) issue_call(table_rows[i].c, table_rows[i].typed, table_rows[i].o);
      drain();

      // random phases: none, sender idle, receiver stall, both
      phase_items = RAND_ITEMS / 4;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_irq_type(32'h0000_0000);
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               write_irq_type(32'hffff_ffff);
               send_idle_pct = 61; recv_stall_pct = 0;
            end
            2: begin
               write_irq_type($urandom);
               send_idle_pct = 0;  recv_stall_pct = 61;
            end
            default: begin
               write_irq_type($urandom);
               send_idle_pct = 36; recv_stall_pct = 36;
            end
         endcase
         for (int n = 0; n < phase_items; n++) begin
            c = random_call();
            issue_call(c, 1'b0, '0);
         end
         drain();
      end

      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
